[rtl/bspsc_pkg.sv]
// Package for the BSP node side and cull block: widths, register indexes, corner selection
// table and CORDIC arctangent table. No dependencies.
`default_nettype none
package bspsc_pkg;
   localparam int ANGLE_STEPS = 16;
   localparam int CW = 38;
   localparam logic [1:0] SIDE_TOP = 2'd0;
   localparam logic [1:0] SIDE_BOTTOM = 2'd1;
   localparam logic [1:0] SIDE_LEFT = 2'd2;
   localparam logic [1:0] SIDE_RIGHT = 2'd3;
   localparam logic [3:0] POS_INSIDE = 4'd5;
   localparam logic [1:0] REG_VIEW_X = 2'd0;
   localparam logic [1:0] REG_VIEW_Y = 2'd1;
   localparam logic [1:0] REG_HEADING = 2'd2;

   // x1, y1, x2, y2 side indexes, two bits each from the lowest bit up
   function automatic logic [7:0] corner_sel(input logic [3:0] pos);
      logic [7:0] r;
      case (pos)
         4'd0: r = {2'd1, 2'd2, 2'd0, 2'd3};
         4'd1: r = {2'd0, 2'd2, 2'd0, 2'd3};
         4'd2: r = {2'd0, 2'd2, 2'd1, 2'd3};
         4'd4: r = {2'd1, 2'd2, 2'd0, 2'd2};
         4'd6: r = {2'd0, 2'd3, 2'd1, 2'd3};
         4'd8: r = {2'd1, 2'd3, 2'd0, 2'd2};
         4'd9: r = {2'd1, 2'd3, 2'd1, 2'd2};
         4'd10: r = {2'd0, 2'd3, 2'd1, 2'd2};
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] atan_unit(input int i);
      logic [15:0] r;
      case (i)
         0: r = 16'd8192;
         1: r = 16'd4836;
         2: r = 16'd2555;
         3: r = 16'd1297;
         4: r = 16'd651;
         5: r = 16'd326;
         6: r = 16'd163;
         7: r = 16'd81;
         8: r = 16'd41;
         9: r = 16'd20;
         10: r = 16'd10;
         11: r = 16'd5;
         12: r = 16'd3;
         13: r = 16'd1;
         14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[rtl/bsp_node_side_and_cull_top.sv]
// BSP node side test and far-child box visibility, fully pipelined.
// Depends on bspsc_pkg for widths and tables.
// Registers from req word to rsp word: stages a, b, c and d, the CORDIC stages, then the output register.
// Throughput: one node per cycle while rsp is not stalled; one CORDIC stage per iteration for each corner.
// Reset: synchronous, clears valid bits and view registers to zero.
`default_nettype none
module bsp_node_side_and_cull_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // split_x, split_y, split_dx, split_dy, first_box_top/bottom/left/right,
   // second_box_top/bottom/left/right, 16 bits each
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // viewer_on_back, far_child_visible, zero fill
   output logic [7:0]        rsp_tdata
);
   localparam int N = bspsc_pkg::ANGLE_STEPS;
   localparam int W = bspsc_pkg::CW;

   logic signed [31:0] view_x_ff, view_y_ff;
   logic [15:0] heading_ff;
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff <= '0;
         view_y_ff <= '0;
         heading_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bspsc_pkg::REG_VIEW_X: view_x_ff <= csr_wdata;
            bspsc_pkg::REG_VIEW_Y: view_y_ff <= csr_wdata;
            bspsc_pkg::REG_HEADING: heading_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // stage a: input
   logic a_v_ff;
   logic signed [15:0] a_f_ff [0:11];
   // stage b: products
   logic b_v_ff, b_vert_ff, b_horiz_ff, b_vback_ff, b_hback_ff;
   logic signed [49:0] b_p1_ff, b_p2_ff;
   logic signed [15:0] b_box_ff [0:1][0:3];
   // stage c: corners
   logic c_v_ff, c_side_ff, c_in_ff;
   logic signed [15:0] c_cx_ff [0:1];
   logic signed [15:0] c_cy_ff [0:1];
   // cordic
   logic v_ff [0:N];
   logic side_ff [0:N];
   logic in_ff [0:N];
   logic zero_ff [0:N][0:1];
   logic signed [W-1:0] x_ff [0:N][0:1];
   logic signed [W-1:0] y_ff [0:N][0:1];
   logic [15:0] z_ff [0:N][0:1];

   logic out_v_ff, out_side_ff, out_vis_ff;

   logic signed [32:0] px, py;
   logic b_back;
   logic signed [15:0] selbox [0:3];
   logic [1:0] bx, by;
   logic [3:0] pos;
   logic [7:0] sel;

   always_comb begin
      px = 33'(view_x_ff) - {a_f_ff[0][15], a_f_ff[0], 16'b0};
      py = 33'(view_y_ff) - {a_f_ff[1][15], a_f_ff[1], 16'b0};
      b_back = b_vert_ff ? b_vback_ff : (b_horiz_ff ? b_hback_ff : !(b_p1_ff < b_p2_ff));
      for (int k = 0; k < 4; k++) selbox[k] = b_back ? b_box_ff[0][k] : b_box_ff[1][k];
      if (view_x_ff <= $signed({selbox[bspsc_pkg::SIDE_LEFT], 16'b0})) bx = 2'd0;
      else if (view_x_ff < $signed({selbox[bspsc_pkg::SIDE_RIGHT], 16'b0})) bx = 2'd1;
      else bx = 2'd2;
      if (view_y_ff >= $signed({selbox[bspsc_pkg::SIDE_TOP], 16'b0})) by = 2'd0;
      else if (view_y_ff > $signed({selbox[bspsc_pkg::SIDE_BOTTOM], 16'b0})) by = 2'd1;
      else by = 2'd2;
      pos = {by, bx};
      sel = bspsc_pkg::corner_sel(pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 12; k++) a_f_ff[k] <= req_tdata[16*k +: 16];
         b_vert_ff <= a_f_ff[2] == 16'sd0;
         b_horiz_ff <= a_f_ff[3] == 16'sd0;
         b_vback_ff <= (view_x_ff <= $signed({a_f_ff[0], 16'b0})) ?
                       (a_f_ff[3] > 16'sd0) : (a_f_ff[3] < 16'sd0);
         b_hback_ff <= (view_y_ff <= $signed({a_f_ff[1], 16'b0})) ?
                       (a_f_ff[2] < 16'sd0) : (a_f_ff[2] > 16'sd0);
         b_p1_ff <= 50'(py * a_f_ff[2]);
         b_p2_ff <= 50'(a_f_ff[3] * px);
         for (int k = 0; k < 4; k++) begin
            b_box_ff[0][k] <= a_f_ff[4 + k];
            b_box_ff[1][k] <= a_f_ff[8 + k];
         end
         c_side_ff <= b_back;
         c_in_ff <= pos == bspsc_pkg::POS_INSIDE;
         c_cx_ff[0] <= selbox[sel[1:0]];
         c_cy_ff[0] <= selbox[sel[3:2]];
         c_cx_ff[1] <= selbox[sel[5:4]];
         c_cy_ff[1] <= selbox[sel[7:6]];
      end
   end

   // stage d: offsets from the viewer, turn left half plane by a half turn
   logic signed [W-1:0] dx [0:1];
   logic signed [W-1:0] dy [0:1];
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         dx[j] = {{(W-32){c_cx_ff[j][15]}}, c_cx_ff[j], 16'b0} - W'(view_x_ff);
         dy[j] = {{(W-32){c_cy_ff[j][15]}}, c_cy_ff[j], 16'b0} - W'(view_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= c_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= c_side_ff;
         in_ff[0] <= c_in_ff;
         for (int j = 0; j < 2; j++) begin
            zero_ff[0][j] <= dx[j] == '0 && dy[j] == '0;
            x_ff[0][j] <= dx[j][W-1] ? -dx[j] : dx[j];
            y_ff[0][j] <= dx[j][W-1] ? -dy[j] : dy[j];
            z_ff[0][j] <= dx[j][W-1] ? 16'h8000 : 16'h0000;
         end
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else if (en) v_ff[k+1] <= v_ff[k];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            in_ff[k+1] <= in_ff[k];
            for (int j = 0; j < 2; j++) begin
               zero_ff[k+1][j] <= zero_ff[k][j];
               if (y_ff[k][j] > 0) begin
                  x_ff[k+1][j] <= x_ff[k][j] + (y_ff[k][j] >>> k);
                  y_ff[k+1][j] <= y_ff[k][j] - (x_ff[k][j] >>> k);
                  z_ff[k+1][j] <= z_ff[k][j] + bspsc_pkg::atan_unit(k);
               end else begin
                  x_ff[k+1][j] <= x_ff[k][j] - (y_ff[k][j] >>> k);
                  y_ff[k+1][j] <= y_ff[k][j] + (x_ff[k][j] >>> k);
                  z_ff[k+1][j] <= z_ff[k][j] - bspsc_pkg::atan_unit(k);
               end
            end
         end
      end
   end

   logic signed [15:0] a1, a2;
   logic signed [16:0] span;
   logic vis;
   always_comb begin
      a1 = $signed((zero_ff[N][0] ? 16'h0000 : z_ff[N][0]) - heading_ff);
      a2 = $signed((zero_ff[N][1] ? 16'h0000 : z_ff[N][1]) - heading_ff);
      span = 17'(a1) - 17'(a2);
      if (in_ff[N]) vis = 1'b1;
      else if (span >= 17'sd32768) vis = 1'b1;
      else if (a1 > 16'sd16384 && a2 > 16'sd16384) vis = 1'b0;
      else if (a1 < -16'sd16384 && a2 < -16'sd16384) vis = 1'b0;
      else vis = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= v_ff[N];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         out_side_ff <= side_ff[N];
         out_vis_ff <= vis;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {6'b0, out_vis_ff, out_side_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");
   a_inside: assert property (@(posedge clock) disable iff (reset)
      en && v_ff[N] && in_ff[N] |=> rsp_tvalid && rsp_tdata[1])
      else $error("viewer inside box but culled");
endmodule
`default_nettype wire
